[hw/rtl/cfpb_pkg.sv]
// ----------------------------------------------------------------------------
// cfpb_pkg
// Shared constants and types for the camera frustum plane builder.
// ----------------------------------------------------------------------------
package cfpb_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned VEC_W  = 16;
  localparam int unsigned TAN_W  = 16;
  localparam int unsigned FAR_W  = 32;
  localparam int unsigned NRM_W  = 22;   // internal plane normal width
  localparam int unsigned ONRM_W = 24;   // normal port width
  localparam int unsigned OFF_W  = 48;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned PROD_W = 2 * VEC_W;           // basis products
  localparam int unsigned DOT_W  = PROD_W + 2;          // sum of three, signed
  localparam int unsigned FT_W   = VEC_W + TAN_W + 1;   // fwd * tan
  localparam int unsigned PP_W   = NRM_W + POS_W;       // normal * position
  localparam int unsigned PS_W   = PP_W + 2;            // sum of three
  localparam int unsigned PN_W   = PS_W + 1;            // negated sum

  // Q2.28 unit and tolerance for the basis checks
  localparam logic signed [DOT_W-1:0] ONE_Q28 = DOT_W'(268435456);
  localparam logic signed [DOT_W-1:0] TOL_Q28 = DOT_W'(2684355);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR   = 2'd2;

  // plane codes
  localparam logic [IDX_W-1:0] PL_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] PL_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] PL_BOTTOM = 3'd2;
  localparam logic [IDX_W-1:0] PL_TOP    = 3'd3;
  localparam logic [IDX_W-1:0] PL_NEAR   = 3'd4;
  localparam logic [IDX_W-1:0] PL_FAR    = 3'd5;

  localparam int unsigned NUM_PAIRS = 6;
  // basis vector pairs: three squared norms, then three dot products
  localparam int unsigned PAIR_A [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};
  localparam int unsigned PAIR_B [NUM_PAIRS] = '{0, 1, 2, 0, 0, 1};

  typedef logic signed [NRM_W-1:0] nrm_t;
  typedef logic signed [VEC_W-1:0] vec_t;

endpackage

[hw/rtl/camera_frustum_plane_builder.sv]
// ----------------------------------------------------------------------------
// camera_frustum_plane_builder
// Builds the six view frustum planes of one camera from position and basis.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a camera transaction is taken at a rising edge with start high and
//   busy low. Config: cfg_we/cfg_index/cfg_data write tan_half_fov_x (0),
//   tan_half_fov_y (1) and far_depth (2); write only while idle.
//   Output: each result is shown for one cycle with result_strobe high.
//   A valid camera gives six planes (left, right, bottom, top, near, far) on
//   consecutive cycles, last_plane set on far. A camera failing a check gives
//   one result with view_valid low and last_plane high.
// Path: a camera passes stage P, stage C, the serializer, stage O1 and the
//   output registers in that order. Planes of a valid camera go one by one
//   through the single offset multiply unit; a reject yields one result.
//   Two product/check stages ahead of the serializer keep accepting while it
//   works; busy rises once both are full.
// Reset: clears all valid bits and loads the register defaults.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module camera_frustum_plane_builder
  import cfpb_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [POS_W-1:0]      pos_x,
  input  logic signed [POS_W-1:0]      pos_y,
  input  logic signed [POS_W-1:0]      pos_z,
  input  logic signed [VEC_W-1:0]      fwd_x,
  input  logic signed [VEC_W-1:0]      fwd_y,
  input  logic signed [VEC_W-1:0]      fwd_z,
  input  logic signed [VEC_W-1:0]      rgt_x,
  input  logic signed [VEC_W-1:0]      rgt_y,
  input  logic signed [VEC_W-1:0]      rgt_z,
  input  logic signed [VEC_W-1:0]      up_x,
  input  logic signed [VEC_W-1:0]      up_y,
  input  logic signed [VEC_W-1:0]      up_z,
  output logic                         result_strobe,
  output logic [IDX_W-1:0]             plane_index,
  output logic signed [ONRM_W-1:0]     normal_x,
  output logic signed [ONRM_W-1:0]     normal_y,
  output logic signed [ONRM_W-1:0]     normal_z,
  output logic signed [OFF_W-1:0]      plane_offset,
  output logic                         view_valid,
  output logic                         last_plane
);

  // configuration
  logic [TAN_W-1:0] tan_x;
  logic [TAN_W-1:0] tan_y;
  logic [FAR_W-1:0] far_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      tan_x     <= TAN_W'(4096);
      tan_y     <= TAN_W'(4096);
      far_depth <= FAR_W'(65536000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAN_X: tan_x     <= cfg_data[TAN_W-1:0];
        REG_TAN_Y: tan_y     <= cfg_data[TAN_W-1:0];
        REG_FAR:   far_depth <= cfg_data[FAR_W-1:0];
        default: ;
      endcase
    end
  end

  // input vectors
  vec_t vin [3][3];
  assign vin[0][0] = fwd_x;
  assign vin[0][1] = fwd_y;
  assign vin[0][2] = fwd_z;
  assign vin[1][0] = rgt_x;
  assign vin[1][1] = rgt_y;
  assign vin[1][2] = rgt_z;
  assign vin[2][0] = up_x;
  assign vin[2][1] = up_y;
  assign vin[2][2] = up_z;

  // stall control
  logic p_valid, c_valid, ser_valid, o1_valid;
  logic p_adv, c_adv, ser_take, ser_done;
  logic ser_ok;
  logic [IDX_W-1:0] ser_cnt;

  assign ser_done = !ser_ok || (ser_cnt == PL_FAR);
  assign ser_take = !ser_valid || ser_done;
  assign c_adv    = !c_valid || ser_take;
  assign p_adv    = !p_valid || c_adv;
  assign busy     = !p_adv;

  // stage P: products
  logic signed [PROD_W-1:0] p_prod [NUM_PAIRS][3];
  logic signed [FT_W-1:0]   p_ftx [3];
  logic signed [FT_W-1:0]   p_fty [3];
  vec_t                     p_vec [3][3];
  logic signed [POS_W-1:0]  p_pos [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_adv) begin
      p_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        for (int k = 0; k < 3; k++) begin
          p_prod[i][k] <= vin[PAIR_A[i]][k] * vin[PAIR_B[i]][k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        p_ftx[k] <= FT_W'(vin[0][k] * $signed({1'b0, tan_x}));
        p_fty[k] <= FT_W'(vin[0][k] * $signed({1'b0, tan_y}));
        for (int a = 0; a < 3; a++) begin
          p_vec[a][k] <= vin[a][k];
        end
      end
      p_pos[0] <= pos_x;
      p_pos[1] <= pos_y;
      p_pos[2] <= pos_z;
    end
  end

  // stage C: checks and plane normals
  logic [NUM_PAIRS-1:0]      chk_pass;
  logic                      c_ok_next;
  nrm_t                      c_nrm_next [6][3];
  logic signed [DOT_W-1:0]   dsum [NUM_PAIRS];
  logic signed [DOT_W-1:0]   ddev [NUM_PAIRS];
  logic signed [FT_W:0]      fxr [3];
  logic signed [FT_W:0]      fyr [3];
  nrm_t                      fx [3];
  nrm_t                      fy [3];
  nrm_t                      bv [3][3];

  always_comb begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      dsum[i] = DOT_W'(p_prod[i][0]) + DOT_W'(p_prod[i][1]) + DOT_W'(p_prod[i][2]);
      ddev[i] = (i < 3) ? (dsum[i] - ONE_Q28) : dsum[i];
      chk_pass[i] = (ddev[i] > -TOL_Q28) && (ddev[i] < TOL_Q28);
    end
    c_ok_next = (&chk_pass) && (tan_x != '0) && (tan_y != '0) && (far_depth != '0);
    for (int k = 0; k < 3; k++) begin
      fxr[k] = ((FT_W+1)'(p_ftx[k]) + (FT_W+1)'(2048)) >>> 12;
      fyr[k] = ((FT_W+1)'(p_fty[k]) + (FT_W+1)'(2048)) >>> 12;
      fx[k]  = fxr[k][NRM_W-1:0];
      fy[k]  = fyr[k][NRM_W-1:0];
      for (int a = 0; a < 3; a++) begin
        bv[a][k] = NRM_W'(p_vec[a][k]);
      end
      c_nrm_next[PL_LEFT][k]   = fx[k] + bv[1][k];
      c_nrm_next[PL_RIGHT][k]  = fx[k] - bv[1][k];
      c_nrm_next[PL_BOTTOM][k] = fy[k] + bv[2][k];
      c_nrm_next[PL_TOP][k]    = fy[k] - bv[2][k];
      c_nrm_next[PL_NEAR][k]   = bv[0][k];
      c_nrm_next[PL_FAR][k]    = -bv[0][k];
    end
  end

  logic                    c_ok;
  nrm_t                    c_nrm [6][3];
  logic signed [POS_W-1:0] c_pos [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_adv) begin
      c_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      c_ok  <= c_ok_next;
      c_nrm <= c_nrm_next;
      c_pos <= p_pos;
    end
  end

  // plane serializer
  nrm_t                    ser_nrm [6][3];
  logic signed [POS_W-1:0] ser_pos [3];
  nrm_t                    nrm_sel [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt   <= PL_LEFT;
    end else if (ser_take) begin
      ser_valid <= c_valid;
      ser_cnt   <= PL_LEFT;
    end else begin
      ser_cnt <= ser_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_ok  <= c_ok;
      ser_nrm <= c_nrm;
      ser_pos <= c_pos;
    end
  end

  always_comb begin
    unique case (ser_cnt)
      PL_LEFT:   nrm_sel = ser_nrm[0];
      PL_RIGHT:  nrm_sel = ser_nrm[1];
      PL_BOTTOM: nrm_sel = ser_nrm[2];
      PL_TOP:    nrm_sel = ser_nrm[3];
      PL_NEAR:   nrm_sel = ser_nrm[4];
      PL_FAR:    nrm_sel = ser_nrm[5];
      default:   nrm_sel = ser_nrm[0];
    endcase
  end

  // stage O1: offset products
  logic signed [PP_W-1:0] o1_prod [3];
  nrm_t                   o1_nrm [3];
  logic [IDX_W-1:0]       o1_idx;
  logic                   o1_ok;
  logic                   o1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
    end else begin
      o1_valid <= ser_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      o1_prod[k] <= nrm_sel[k] * ser_pos[k];
      o1_nrm[k]  <= ser_ok ? nrm_sel[k] : '0;
    end
    o1_idx  <= ser_ok ? ser_cnt : PL_LEFT;
    o1_ok   <= ser_ok;
    o1_last <= ser_done;
  end

  // stage O2: offset sum, rounding, far term
  logic signed [PS_W-1:0] psum;
  logic signed [PN_W-1:0] pneg;
  logic signed [PN_W-1:0] prnd;
  logic signed [PN_W-1:0] poff;

  always_comb begin
    psum = PS_W'(o1_prod[0]) + PS_W'(o1_prod[1]) + PS_W'(o1_prod[2]);
    pneg = -PN_W'(psum);
    prnd = (pneg + PN_W'(8192)) >>> 14;
    poff = (o1_idx == PL_FAR) ? prnd + $signed(PN_W'(far_depth)) : prnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= o1_valid;
    end
  end

  always_ff @(posedge clk) begin
    plane_index  <= o1_idx;
    normal_x     <= ONRM_W'(o1_nrm[0]);
    normal_y     <= ONRM_W'(o1_nrm[1]);
    normal_z     <= ONRM_W'(o1_nrm[2]);
    plane_offset <= o1_ok ? poff[OFF_W-1:0] : '0;
    view_valid   <= o1_ok;
    last_plane   <= o1_last;
  end

  // assertions
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !view_valid |-> last_plane && plane_index == PL_LEFT)
    else $error("rejected camera must give a single result");

  a_last_on_far: assert property (@(posedge clk) disable iff (rst)
    result_strobe && view_valid |-> (last_plane == (plane_index == PL_FAR)))
    else $error("last_plane must mark the far plane only");

  a_plane_sequence: assert property (@(posedge clk) disable iff (rst)
    result_strobe && view_valid && !last_plane |=>
      result_strobe && view_valid && plane_index == $past(plane_index) + IDX_W'(1))
    else $error("planes of one camera must follow back to back");

  a_ser_hold: assert property (@(posedge clk) disable iff (rst)
    ser_valid && !ser_done |=> ser_valid && $stable(ser_ok))
    else $error("serializer lost a camera mid transaction");

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> p_valid && c_valid && ser_valid)
    else $error("busy without a full pipeline");

endmodule
